// File: sv/otr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package otr_pkg;

    localparam int TIMER_BITS = 10;
    localparam int CFG_WIDTH  = 10;
    localparam int NUM_CFG    = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd6;

    localparam logic [7:0] CMD_SKIP     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [9:0] FRACTION_STEP = 10'd625;

    typedef logic [CFG_WIDTH-1:0] t_cfg_word;
    typedef t_cfg_word [NUM_CFG-1:0] t_cfg_regs;
    typedef logic [TIMER_BITS-1:0] t_timer;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_RST1  = 4'd1,
        PH_SKIP1 = 4'd2,
        PH_CONV  = 4'd3,
        PH_POLL  = 4'd4,
        PH_RST2  = 4'd5,
        PH_SKIP2 = 4'd6,
        PH_RPAD  = 4'd7,
        PH_RDLO  = 4'd8,
        PH_RDHI  = 4'd9,
        PH_RST3  = 4'd10
    } t_phase;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [6:0]  temp_whole;
        logic [13:0] temp_fraction;
    } t_step_res;

    function automatic logic is_reset(input t_phase p);
        return (p == PH_RST1) || (p == PH_RST2) || (p == PH_RST3);
    endfunction

    function automatic logic is_read(input t_phase p);
        return (p == PH_POLL) || (p == PH_RDLO) || (p == PH_RDHI);
    endfunction

    function automatic logic [7:0] cmd_of(input t_phase p);
        logic [7:0] c;
        unique case (p)
            PH_CONV: c = CMD_CONVERT;
            PH_RPAD: c = CMD_READ_PAD;
            default: c = CMD_SKIP;
        endcase
        return c;
    endfunction

    // a zero setting still lasts one tick
    function automatic t_timer ticks_of(input t_cfg_word v);
        t_timer t;
        t = t_timer'(v);
        return (t == '0) ? t_timer'(1) : t;
    endfunction

endpackage

`default_nettype wire

// File: sv/otr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface otr_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic bus_level;

    modport source(output valid, output start_request, output bus_level, input ready);
    modport sink(input valid, input start_request, input bus_level, output ready);
endinterface

`default_nettype wire

// File: sv/otr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface otr_out_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [6:0]  temp_whole;
    logic [13:0] temp_fraction;

    modport source(output valid, output drive_low, output busy_res, output done_res,
                   output temp_whole, output temp_fraction, input ready);
    modport sink(input valid, input drive_low, input busy_res, input done_res,
                 input temp_whole, input temp_fraction, output ready);
endinterface

`default_nettype wire

// File: sv/otr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module otr_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_start,
    input  wire logic               i_bus,
    input  wire otr_pkg::t_cfg_regs i_cfg,
    output otr_pkg::t_step_res      o_res
);

    otr_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_part, n_part;
    otr_pkg::t_timer r_cnt, n_cnt;
    logic [2:0]      r_bits, n_bits;
    logic [7:0]      r_shift, n_shift;
    logic [7:0]      r_lo, n_lo;
    logic [7:0]      r_hi, n_hi;
    logic [6:0]      r_whole, n_whole;
    logic [13:0]     r_frac, n_frac;

    logic            drive;
    logic            done;
    logic [7:0]      cmd;
    logic            cmd_bit;
    logic            ends;
    otr_pkg::t_timer dur;
    logic [otr_pkg::CFG_IDX_W-1:0] sel;

    always_comb begin
        n_phase = r_phase;
        n_part  = r_part;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_whole = r_whole;
        n_frac  = r_frac;
        drive   = 1'b0;
        done    = 1'b0;
        cmd     = otr_pkg::CMD_SKIP;
        cmd_bit = 1'b0;
        sel     = otr_pkg::CFG_SLOT_START;
        dur     = otr_pkg::t_timer'(1);
        ends    = 1'b0;

        if (r_phase == otr_pkg::PH_IDLE && i_start) begin
            n_phase = otr_pkg::PH_RST1;
            n_part  = 2'd0;
            n_cnt   = '0;
            n_bits  = 3'd0;
            n_shift = 8'd0;
        end

        if (n_phase != otr_pkg::PH_IDLE) begin
            if (n_part == 2'd3) begin
                n_part = 2'd0;
            end
            if (otr_pkg::is_reset(n_phase)) begin
                drive = (n_part == 2'd0);
                sel   = otr_pkg::CFG_IDX_W'(n_part);
            end else if (otr_pkg::is_read(n_phase)) begin
                drive = (n_part == 2'd0);
                case (n_part)
                    2'd0:    sel = otr_pkg::CFG_SLOT_START;
                    2'd1:    sel = otr_pkg::CFG_READ_SAMPLE;
                    default: sel = otr_pkg::CFG_READ_TAIL;
                endcase
                if (n_part == 2'd2 && n_cnt == '0) begin
                    n_shift = {i_bus, n_shift[7:1]};
                end
            end else begin
                cmd     = otr_pkg::cmd_of(n_phase);
                cmd_bit = cmd[n_bits];
                if (n_part > 2'd1) begin
                    n_part = 2'd1;
                end
                drive = (n_part == 2'd0) ? 1'b1 : ~cmd_bit;
                sel   = (n_part == 2'd0) ? otr_pkg::CFG_SLOT_START : otr_pkg::CFG_WRITE_HOLD;
            end
            dur  = otr_pkg::ticks_of(i_cfg[sel]);
            ends = ({1'b0, n_cnt} + 1'b1) >= {1'b0, dur};

            if (!ends) begin
                n_cnt = n_cnt + 1'b1;
            end else begin
                n_cnt = '0;
                if (otr_pkg::is_reset(n_phase)) begin
                    if (n_part < 2'd2) begin
                        n_part = n_part + 1'b1;
                    end else if (n_phase == otr_pkg::PH_RST3) begin
                        n_whole = {n_hi[2:0], n_lo[7:4]};
                        n_frac  = 14'(n_lo[3:0]) * 14'(otr_pkg::FRACTION_STEP);
                        n_phase = otr_pkg::PH_IDLE;
                        n_part  = 2'd0;
                        n_bits  = 3'd0;
                        done    = 1'b1;
                    end else begin
                        n_phase = otr_pkg::t_phase'(n_phase + 1'b1);
                        n_part  = 2'd0;
                        n_bits  = 3'd0;
                    end
                end else if (otr_pkg::is_read(n_phase)) begin
                    if (n_part < 2'd2) begin
                        n_part = n_part + 1'b1;
                    end else if (n_phase == otr_pkg::PH_POLL) begin
                        n_part = 2'd0;
                        if (n_shift[7]) begin
                            n_phase = otr_pkg::t_phase'(n_phase + 1'b1);
                            n_bits  = 3'd0;
                        end
                    end else begin
                        n_part = 2'd0;
                        if (&n_bits) begin
                            if (n_phase == otr_pkg::PH_RDLO) begin
                                n_lo = n_shift;
                            end else begin
                                n_hi = n_shift;
                            end
                            n_phase = otr_pkg::t_phase'(n_phase + 1'b1);
                            n_bits  = 3'd0;
                        end else begin
                            n_bits = n_bits + 1'b1;
                        end
                    end
                end else begin
                    if (n_part == 2'd0) begin
                        n_part = 2'd1;
                    end else if (&n_bits) begin
                        n_phase = otr_pkg::t_phase'(n_phase + 1'b1);
                        n_part  = 2'd0;
                        n_bits  = 3'd0;
                    end else begin
                        n_part = 2'd0;
                        n_bits = n_bits + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_res.drive_low     = drive;
        o_res.busy_res      = (n_phase != otr_pkg::PH_IDLE);
        o_res.done_res      = done;
        o_res.temp_whole    = n_whole;
        o_res.temp_fraction = n_frac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= otr_pkg::PH_IDLE;
            r_part  <= 2'd0;
            r_cnt   <= '0;
            r_bits  <= 3'd0;
            r_shift <= 8'd0;
            r_lo    <= 8'd0;
            r_hi    <= 8'd0;
            r_whole <= 7'd0;
            r_frac  <= 14'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_part  <= n_part;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_whole <= n_whole;
            r_frac  <= n_frac;
        end
    end

endmodule

`default_nettype wire

// File: sv/one_wire_temperature_reader_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                              transaction
// i_item    in   start_request, bus_level                             one 1 us tick
// o_result  out  drive_low, busy_res, done_res, temp_whole, temp_frac  one per tick
// i_cfg_*   in   7 timing registers, 10 bits, index 0..6              write, no wait
//
// One tick per cycle: the sequencer step is one pass through otr_core into the
// result register, so a tick is accepted every cycle while o_result drains.
// The result of an accepted tick is registered and shows on o_result in the next cycle.
// Synchronous reset clears the sequencer, its stored temperature and the result valid
// flag, and restores timing defaults. i_item stalls only while a result is held and o_result.ready is low.

module one_wire_temperature_reader_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    otr_in_if.sink                             i_item,
    otr_out_if.source                          o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [otr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire otr_pkg::t_cfg_word            i_cfg_data
);

    otr_pkg::t_cfg_regs r_cfg;
    otr_pkg::t_step_res step_res;
    otr_pkg::t_step_res r_res;
    logic               r_valid;
    logic               accept;

    assign i_item.ready = !r_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[otr_pkg::CFG_RESET_LOW]     <= otr_pkg::t_cfg_word'(480);
            r_cfg[otr_pkg::CFG_PRESENCE_WAIT] <= otr_pkg::t_cfg_word'(60);
            r_cfg[otr_pkg::CFG_RESET_TAIL]    <= otr_pkg::t_cfg_word'(420);
            r_cfg[otr_pkg::CFG_SLOT_START]    <= otr_pkg::t_cfg_word'(1);
            r_cfg[otr_pkg::CFG_WRITE_HOLD]    <= otr_pkg::t_cfg_word'(60);
            r_cfg[otr_pkg::CFG_READ_SAMPLE]   <= otr_pkg::t_cfg_word'(14);
            r_cfg[otr_pkg::CFG_READ_TAIL]     <= otr_pkg::t_cfg_word'(45);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                otr_pkg::CFG_RESET_LOW:     r_cfg[otr_pkg::CFG_RESET_LOW]     <= i_cfg_data;
                otr_pkg::CFG_PRESENCE_WAIT: r_cfg[otr_pkg::CFG_PRESENCE_WAIT] <= i_cfg_data;
                otr_pkg::CFG_RESET_TAIL:    r_cfg[otr_pkg::CFG_RESET_TAIL]    <= i_cfg_data;
                otr_pkg::CFG_SLOT_START:    r_cfg[otr_pkg::CFG_SLOT_START]    <= i_cfg_data;
                otr_pkg::CFG_WRITE_HOLD:    r_cfg[otr_pkg::CFG_WRITE_HOLD]    <= i_cfg_data;
                otr_pkg::CFG_READ_SAMPLE:   r_cfg[otr_pkg::CFG_READ_SAMPLE]   <= i_cfg_data;
                otr_pkg::CFG_READ_TAIL:     r_cfg[otr_pkg::CFG_READ_TAIL]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    otr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_start (i_item.start_request),
        .i_bus   (i_item.bus_level),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.drive_low     = r_res.drive_low;
    assign o_result.busy_res      = r_res.busy_res;
    assign o_result.done_res      = r_res.done_res;
    assign o_result.temp_whole    = r_res.temp_whole;
    assign o_result.temp_fraction = r_res.temp_fraction;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.done_res) |-> !o_result.busy_res)
        else $error("done reported while still busy");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.busy_res) |-> !o_result.drive_low)
        else $error("line driven low while idle");

    a_fraction_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.temp_fraction <= 14'd9375))
        else $error("fraction out of range");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |-> !i_item.ready)
        else $error("tick accepted over a held result");

endmodule

`default_nettype wire

// File: dv/one_wire_temperature_reader_unit_test.sv
`timescale 1ns / 1ps

module one_wire_temperature_reader_unit_test;

    localparam int STALL_LIMIT = 2000;
    localparam logic [otr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic req;
        logic level;
    } t_sensor_tick;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [otr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    otr_pkg::t_cfg_word i_cfg_data;

    otr_in_if tick_ch();
    otr_out_if step_ch();

    one_wire_temperature_reader_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (tick_ch),
        .o_result    (step_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_sensor_tick         pending_ticks[$];
    otr_pkg::t_step_res   predicted_steps[$];
    int unsigned  mismatches = 0;
    int unsigned  steps_seen = 0;
    int unsigned  send_gap = 0;
    int unsigned  recv_gap = 0;
    int unsigned  quiet_cycles = 0;
    logic         idle_on = 1'b0;

    // sequencer shadow
    otr_pkg::t_cfg_regs timing;
    otr_pkg::t_phase    ph;
    logic [1:0]      part;
    otr_pkg::t_timer cnt;
    logic [2:0]      bitn;
    logic [7:0]      shreg;
    logic [7:0]      pad_lo;
    logic [7:0]      pad_hi;
    logic [6:0]      whole;
    logic [13:0]     frac;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 70) return 0;
        if (r < 98) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [10:0] part_ticks(input logic [otr_pkg::CFG_IDX_W-1:0] idx);
        logic [10:0] v;
        v = {1'b0, timing[idx]};
        return (v == '0) ? 11'd1 : v;
    endfunction

    function automatic void next_phase();
        ph = otr_pkg::t_phase'(ph + 4'd1);
        part = '0;
        bitn = '0;
    endfunction

    function automatic otr_pkg::t_step_res step_sequencer(input logic req, input logic level);
        otr_pkg::t_step_res r;
        logic [10:0] len;
        logic [7:0] cmd;
        logic drv;
        logic done;
        logic in_reset;
        logic in_read;
        drv = 1'b0;
        done = 1'b0;
        len = 11'd1;
        if (ph == otr_pkg::PH_IDLE && req) begin
            ph = otr_pkg::PH_RST1;
            part = '0;
            cnt = '0;
            bitn = '0;
            shreg = '0;
        end
        in_reset = (ph == otr_pkg::PH_RST1) || (ph == otr_pkg::PH_RST2) ||
                   (ph == otr_pkg::PH_RST3);
        in_read = (ph == otr_pkg::PH_POLL) || (ph == otr_pkg::PH_RDLO) ||
                  (ph == otr_pkg::PH_RDHI);
        if (ph != otr_pkg::PH_IDLE) begin
            if (in_reset) begin
                drv = (part == 2'd0);
                len = part_ticks(part == 2'd0 ? otr_pkg::CFG_RESET_LOW :
                                 part == 2'd1 ? otr_pkg::CFG_PRESENCE_WAIT :
                                 otr_pkg::CFG_RESET_TAIL);
            end else if (in_read) begin
                drv = (part == 2'd0);
                len = part_ticks(part == 2'd0 ? otr_pkg::CFG_SLOT_START :
                                 part == 2'd1 ? otr_pkg::CFG_READ_SAMPLE :
                                 otr_pkg::CFG_READ_TAIL);
                if (part == 2'd2 && cnt == '0) shreg = {level, shreg[7:1]};
            end else begin
                cmd = (ph == otr_pkg::PH_CONV) ? otr_pkg::CMD_CONVERT :
                      (ph == otr_pkg::PH_RPAD) ? otr_pkg::CMD_READ_PAD : otr_pkg::CMD_SKIP;
                drv = (part == 2'd0) ? 1'b1 : ~cmd[bitn];
                len = part_ticks(part == 2'd0 ? otr_pkg::CFG_SLOT_START :
                                 otr_pkg::CFG_WRITE_HOLD);
            end

            if ({1'b0, cnt} + 11'd1 < len) begin
                cnt = cnt + 1'b1;
            end else begin
                cnt = '0;
                if (in_reset) begin
                    if (part < 2'd2) begin
                        part = part + 1'b1;
                    end else if (ph == otr_pkg::PH_RST3) begin
                        whole = {pad_hi[2:0], pad_lo[7:4]};
                        frac = 14'(pad_lo[3:0]) * 14'(otr_pkg::FRACTION_STEP);
                        ph = otr_pkg::PH_IDLE;
                        part = '0;
                        bitn = '0;
                        done = 1'b1;
                    end else begin
                        next_phase();
                    end
                end else if (in_read) begin
                    if (part < 2'd2) begin
                        part = part + 1'b1;
                    end else if (ph == otr_pkg::PH_POLL) begin
                        part = '0;
                        if (shreg[7]) next_phase();
                    end else begin
                        part = '0;
                        if (bitn == 3'd7) begin
                            if (ph == otr_pkg::PH_RDLO) pad_lo = shreg;
                            else pad_hi = shreg;
                            next_phase();
                        end else begin
                            bitn = bitn + 1'b1;
                        end
                    end
                end else begin
                    if (part == 2'd0) begin
                        part = 2'd1;
                    end else if (bitn == 3'd7) begin
                        next_phase();
                    end else begin
                        part = '0;
                        bitn = bitn + 1'b1;
                    end
                end
            end
        end
        r.drive_low = drv;
        r.busy_res = (ph != otr_pkg::PH_IDLE);
        r.done_res = done;
        r.temp_whole = whole;
        r.temp_fraction = frac;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s got %0d expected %0d", steps_seen, what, got,
                     want);
    endtask

    // driver
    always @(posedge i_clk) begin : driver
        t_sensor_tick nxt;
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
            tick_ch.start_request <= 1'b0;
            tick_ch.bus_level <= 1'b0;
            send_gap <= 0;
        end else if (!tick_ch.valid || tick_ch.ready) begin
            if (send_gap != 0) begin
                tick_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_ticks.size() != 0) begin
                nxt = pending_ticks.pop_front();
                tick_ch.valid <= 1'b1;
                tick_ch.start_request <= nxt.req;
                tick_ch.bus_level <= nxt.level;
                send_gap <= pick_gap();
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_ch.ready <= 1'b0;
            recv_gap <= 0;
        end else if (recv_gap != 0) begin
            step_ch.ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            step_ch.ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        otr_pkg::t_step_res want;
        if (i_rst_n) begin
            if (tick_ch.valid && tick_ch.ready)
                predicted_steps.push_back(step_sequencer(tick_ch.start_request,
                                                         tick_ch.bus_level));
            if (step_ch.valid && step_ch.ready) begin
                steps_seen++;
                if (predicted_steps.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = predicted_steps.pop_front();
                    if (step_ch.drive_low !== want.drive_low)
                        report_mismatch("drive_low", step_ch.drive_low, want.drive_low);
                    if (step_ch.busy_res !== want.busy_res)
                        report_mismatch("busy_res", step_ch.busy_res, want.busy_res);
                    if (step_ch.done_res !== want.done_res)
                        report_mismatch("done_res", step_ch.done_res, want.done_res);
                    if (step_ch.temp_whole !== want.temp_whole)
                        report_mismatch("temp_whole", step_ch.temp_whole, want.temp_whole);
                    if (step_ch.temp_fraction !== want.temp_fraction)
                        report_mismatch("temp_fraction", step_ch.temp_fraction,
                                        want.temp_fraction);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((tick_ch.valid && tick_ch.ready) || (step_ch.valid && step_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("one_wire_temperature_reader_unit_test: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_tick(input logic req, input logic level);
        t_sensor_tick t;
        t.req = req;
        t.level = level;
        pending_ticks.push_back(t);
    endtask

    task automatic push_random(input int unsigned n);
        repeat (n) push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_sent();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_ticks.size() != 0 || tick_ch.valid);
    endtask

    task automatic drain();
        wait_sent();
        while (predicted_steps.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (3) @(posedge i_clk);
    endtask

    // keep ticking with no new request until the reading completes
    task automatic finish_reading();
        forever begin
            wait_sent();
            if (ph == otr_pkg::PH_IDLE) break;
            repeat (32) push_tick(1'b0, 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    task automatic write_reg(input logic [otr_pkg::CFG_IDX_W-1:0] idx,
                             input otr_pkg::t_cfg_word val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx < otr_pkg::NUM_CFG) timing[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_timing(input otr_pkg::t_cfg_regs v);
        for (int i = 0; i < otr_pkg::NUM_CFG; i++) write_reg(otr_pkg::CFG_IDX_W'(i), v[i]);
    endtask

    initial begin : stimulus
        otr_pkg::t_cfg_regs v;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.start_request = 1'b0;
        tick_ch.bus_level = 1'b0;
        step_ch.ready = 1'b0;
        timing[otr_pkg::CFG_RESET_LOW] = 10'd480;
        timing[otr_pkg::CFG_PRESENCE_WAIT] = 10'd60;
        timing[otr_pkg::CFG_RESET_TAIL] = 10'd420;
        timing[otr_pkg::CFG_SLOT_START] = 10'd1;
        timing[otr_pkg::CFG_WRITE_HOLD] = 10'd60;
        timing[otr_pkg::CFG_READ_SAMPLE] = 10'd14;
        timing[otr_pkg::CFG_READ_TAIL] = 10'd45;
        ph = otr_pkg::PH_IDLE;
        part = '0;
        cnt = '0;
        bitn = '0;
        shreg = '0;
        pad_lo = '0;
        pad_hi = '0;
        whole = '0;
        frac = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default timing: idle ticks, start, requests while busy
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        for (int i = 0; i < 20; i++) push_tick(i % 3 == 0, i[0]);
        idle_on = 1'b1;
        drain();

        // shortest parts mid-sequence, write to an unused index
        v = '0;
        apply_timing(v);
        write_reg(CFG_UNUSED, '1);
        finish_reading();

        // sensor that is slow to report ready
        idle_on = 1'b0;
        push_tick(1'b1, 1'b0);
        repeat (90) push_tick(1'b0, 1'b0);
        drain();
        idle_on = 1'b1;
        push_random(30);
        finish_reading();

        // random short parts
        for (int i = 0; i < otr_pkg::NUM_CFG; i++)
            v[i] = otr_pkg::t_cfg_word'($urandom_range(0, 2));
        apply_timing(v);
        push_random(60);
        finish_reading();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("one_wire_temperature_reader_unit_test: PASS");
        end else begin
            $display("one_wire_temperature_reader_unit_test: FAIL");
        end
        $finish;
    end

endmodule
